// ===== hdl/ofd_pkg.sv =====
// ----------------------------------------------------------------------------
// Odometry frame deframer package
// Frame layout constants, status codes and shared widths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ofd_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned WordW       = 32;
  localparam int unsigned FrameLen    = 29;
  localparam int unsigned PayloadLen  = 24;
  localparam int unsigned PayloadFrst = 4;
  localparam int unsigned NumWords    = PayloadLen / 4;
  localparam int unsigned CountW      = $clog2(FrameLen);

  localparam logic [ByteW-1:0] HdrSync = 8'hAA;
  localparam logic [ByteW-1:0] HdrId   = 8'hF1;

  // Positions within a frame
  localparam logic [CountW-1:0] PosHdr0   = CountW'(0);
  localparam logic [CountW-1:0] PosHdr1   = CountW'(1);
  localparam logic [CountW-1:0] PosHdr2   = CountW'(2);
  localparam logic [CountW-1:0] PosHdr3   = CountW'(3);
  localparam logic [CountW-1:0] PosSum    = CountW'(FrameLen - 1);

  typedef enum logic [1:0] {
    StGood = 2'd0,
    StHdr  = 2'd1,
    StSum  = 2'd2
  } status_e;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [WordW-1:0] word_t;

endpackage

// ===== hdl/ofd_rx_if.sv =====
// ----------------------------------------------------------------------------
// Receive byte channel
// Valid/ready channel carrying one received serial byte per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ofd_rx_if;
  import ofd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/ofd_res_if.sv =====
// ----------------------------------------------------------------------------
// Frame result channel
// Valid/ready channel carrying a frame status and six decoded payload words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ofd_res_if;
  import ofd_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  word_t      vel_x_bits;
  word_t      vel_y_bits;
  word_t      turn_rate_bits;
  word_t      pos_x_bits;
  word_t      pos_y_bits;
  word_t      heading_bits;

  modport source (
    output valid, output frame_status, output vel_x_bits, output vel_y_bits,
    output turn_rate_bits, output pos_x_bits, output pos_y_bits,
    output heading_bits, input ready
  );
  modport sink (
    input valid, input frame_status, input vel_x_bits, input vel_y_bits,
    input turn_rate_bits, input pos_x_bits, input pos_y_bits,
    input heading_bits, output ready
  );
endinterface

// ===== hdl/odometry_frame_deframer_top.sv =====
// Result: registered; it appears on res_o in the cycle after the byte that
// closes it (the fourth byte on a header error, the checksum byte otherwise).
// Throughput: one byte per cycle; the next byte is taken while a result waits,
// except a closing byte, which waits until the result register is free.
// Reset: count, running sum and result valid clear and the header flag sets at
// once; the payload shift line is not reset.
// ----------------------------------------------------------------------------
// Odometry frame deframer
// Assembles 29-byte frames, checks header and additive checksum, and emits
// six little-endian 32-bit payload words per good frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module odometry_frame_deframer_top (
  input  logic clk_i,
  input  logic rst_ni,
  ofd_rx_if.sink    rx_i,
  ofd_res_if.source res_o
);
  import ofd_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  byte_t             sum_q, sum_d;
  logic              hdr_ok_q, hdr_ok_d;
  byte_t             store_q [PayloadLen];

  logic              res_valid_q, res_valid_d;
  status_e           status_q, status_d;
  word_t             words_q [NumWords];
  word_t             words_d [NumWords];
  word_t             frame_words [NumWords];

  logic              accept;
  logic              closing;
  logic              is_payload;
  logic              hdr_fail;

  // A closing byte is known from state alone, so ready never looks at the data
  assign closing     = (count_q == PosSum) || ((count_q == PosHdr3) && !hdr_ok_q);
  assign rx_i.ready  = !res_valid_q || res_o.ready || !closing;
  assign accept      = rx_i.valid && rx_i.ready;
  assign is_payload  = (count_q > PosHdr3) && (count_q != PosSum);
  assign hdr_fail    = (count_q == PosHdr3) && !hdr_ok_q;

  always_comb begin
    for (int k = 0; k < NumWords; k++) begin
      frame_words[k] = {store_q[4*k+3], store_q[4*k+2], store_q[4*k+1], store_q[4*k]};
    end
  end

  always_comb begin
    count_d     = count_q;
    sum_d       = sum_q;
    hdr_ok_d    = hdr_ok_q;
    res_valid_d = res_valid_q && !res_o.ready;
    status_d    = status_q;
    words_d     = words_q;
    if (accept) begin
      if (count_q == PosSum) begin
        res_valid_d = 1'b1;
        count_d     = '0;
        sum_d       = '0;
        hdr_ok_d    = 1'b1;
        if (rx_i.rx_byte == sum_q) begin
          status_d = StGood;
          words_d  = frame_words;
        end else begin
          status_d = StSum;
          for (int k = 0; k < NumWords; k++) words_d[k] = '0;
        end
      end else if (hdr_fail) begin
        res_valid_d = 1'b1;
        count_d     = '0;
        sum_d       = '0;
        hdr_ok_d    = 1'b1;
        status_d    = StHdr;
        for (int k = 0; k < NumWords; k++) words_d[k] = '0;
      end else begin
        count_d = count_q + CountW'(1);
        sum_d   = sum_q + rx_i.rx_byte;
        case (count_q)
          PosHdr0, PosHdr1: begin
            if (rx_i.rx_byte != HdrSync) hdr_ok_d = 1'b0;
          end
          PosHdr2: begin
            if (rx_i.rx_byte != HdrId) hdr_ok_d = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sum_q       <= '0;
      hdr_ok_q    <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      sum_q       <= sum_d;
      hdr_ok_q    <= hdr_ok_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload bytes shift in at the top; after 24 of them byte 4 sits at entry 0
  always_ff @(posedge clk_i) begin
    if (accept && is_payload) begin
      for (int i = 0; i < PayloadLen - 1; i++) store_q[i] <= store_q[i+1];
      store_q[PayloadLen-1] <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    words_q  <= words_d;
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.frame_status   = status_q;
  assign res_o.vel_x_bits     = words_q[0];
  assign res_o.vel_y_bits     = words_q[1];
  assign res_o.turn_rate_bits = words_q[2];
  assign res_o.pos_x_bits     = words_q[3];
  assign res_o.pos_y_bits     = words_q[4];
  assign res_o.heading_bits   = words_q[5];

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= PosSum)
    else $error("frame byte count beyond checksum position");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (status_q != StGood)) |->
      (words_q[0] == '0 && words_q[1] == '0 && words_q[2] == '0 &&
       words_q[3] == '0 && words_q[4] == '0 && words_q[5] == '0))
    else $error("error result carries nonzero payload");

  a_close_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && closing) |=> (res_valid_q && count_q == '0 && sum_q == '0 && hdr_ok_q))
    else $error("closing byte did not produce a result and restart the frame");

  a_hdr_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && hdr_fail) |=> (status_q == StHdr))
    else $error("header failure not reported");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_o.ready && closing) |-> !rx_i.ready)
    else $error("closing byte taken while result register is occupied");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry frame deframer testbench
// Drives received bytes as good frames, header and checksum errors and noise.
// A scoreboard tracks the frame state, predicts every result and compares it
// field by field with what the block emits. Both channels stall at random.
// ----------------------------------------------------------------------------

module tb_top;
  import ofd_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned RandBytes  = 900;

  typedef struct {
    logic [1:0] status;
    word_t      w [NumWords];
  } frame_result_t;

  class frame_scoreboard;
    byte_t             payload [PayloadLen];
    logic [CountW-1:0] pos;
    byte_t             sum;
    bit                hdr_ok;
    frame_result_t     pending_q [$];
    int unsigned       n_expected;
    int unsigned       n_checked;
    int unsigned       n_errors;

    function new();
      pos        = '0;
      sum        = '0;
      hdr_ok     = 1'b1;
      n_expected = 0;
      n_checked  = 0;
      n_errors   = 0;
    endfunction

    // Advance the frame state by one accepted byte; queue any result it closes.
    function void note_byte(byte_t b);
      frame_result_t r;
      r.status = StGood;
      r.w      = '{default: '0};
      if (pos == PosSum) begin
        if (b == sum) begin
          for (int k = 0; k < NumWords; k++) begin
            r.w[k] = {payload[4*k+3], payload[4*k+2], payload[4*k+1], payload[4*k]};
          end
        end else begin
          r.status = StSum;
        end
        pending_q = {pending_q, r};
        n_expected++;
        pos    = '0;
        sum    = '0;
        hdr_ok = 1'b1;
        return;
      end
      if (pos == PosHdr0 || pos == PosHdr1) begin
        if (b != HdrSync) hdr_ok = 1'b0;
      end else if (pos == PosHdr2) begin
        if (b != HdrId) hdr_ok = 1'b0;
      end else if (pos >= PayloadFrst) begin
        payload[pos - PayloadFrst] = b;
      end
      sum = sum + b;
      if (pos == PosHdr3 && !hdr_ok) begin
        r.status = StHdr;
        pending_q = {pending_q, r};
        n_expected++;
        pos    = '0;
        sum    = '0;
        hdr_ok = 1'b1;
        return;
      end
      pos = pos + 1'b1;
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      string         label [NumWords];
      label = '{"vel_x_bits", "vel_y_bits", "turn_rate_bits",
                "pos_x_bits", "pos_y_bits", "heading_bits"};
      n_checked++;
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing pending, frame_status %0d", $time, got.status);
        n_errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: frame_status expected %0d got %0d", $time, want.status, got.status);
        n_errors++;
      end
      for (int k = 0; k < NumWords; k++) begin
        if (got.w[k] !== want.w[k]) begin
          $display("%0t: %s expected %h got %h", $time, label[k], want.w[k], got.w[k]);
          n_errors++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ofd_rx_if  rx_if ();
  ofd_res_if res_if ();

  odometry_frame_deframer_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if)
  );

  frame_scoreboard sb = new();
  int unsigned     xfer_cnt = 0;
  int unsigned     n_sent   = 0;
  bit              calm     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Offer one byte and hold it until the transaction completes.
  task automatic send_byte(input byte_t b);
    calm = (n_sent >= 300 && n_sent < 450);
    while (!calm && $urandom_range(99) < 11) begin
      rx_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    sb.note_byte(b);
    xfer_cnt++;
    n_sent++;
    @(negedge clk_i);
  endtask

  // Send a header and, when the header is valid, the payload and checksum.
  task automatic send_frame(input byte_t h0, input byte_t h1, input byte_t h2,
                            input byte_t h3, input byte_t body [PayloadLen],
                            input bit bad_sum);
    byte_t chk;
    chk = h0 + h1 + h2 + h3;
    send_byte(h0);
    send_byte(h1);
    send_byte(h2);
    send_byte(h3);
    if (h0 != HdrSync || h1 != HdrSync || h2 != HdrId) return;
    for (int i = 0; i < PayloadLen; i++) begin
      send_byte(body[i]);
      chk = chk + body[i];
    end
    if (bad_sum) chk = chk + byte_t'($urandom_range(1, 255));
    send_byte(chk);
  endtask

  // Receiver: random back-pressure plus one long hold-off to fill the block.
  initial begin
    bit held;
    held         = 1'b0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && sb.n_checked >= 8) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      res_if.ready <= calm || ($urandom_range(99) >= 11);
    end
  end

  always @(posedge clk_i) begin : res_monitor
    frame_result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.status = res_if.frame_status;
      got.w[0]   = res_if.vel_x_bits;
      got.w[1]   = res_if.vel_y_bits;
      got.w[2]   = res_if.turn_rate_bits;
      got.w[3]   = res_if.pos_x_bits;
      got.w[4]   = res_if.pos_y_bits;
      got.w[5]   = res_if.heading_bits;
      sb.check_result(got);
      xfer_cnt++;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    int unsigned last;
    quiet = 0;
    last  = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if (xfer_cnt != last) begin
        last  = xfer_cnt;
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    byte_t       body [PayloadLen];
    byte_t       hdr [4];
    int unsigned sel;
    int unsigned n;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    rst_ni        = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: wrong first byte, wrong id byte, then one good frame whose
    // payload holds all-ones, all-zeros and mixed words.
    for (int i = 0; i < PayloadLen; i++) begin
      body[i] = (i < 4) ? 8'hFF : (i < 8) ? 8'h00 : ((i % 2) ? 8'hFF : 8'h00);
    end
    send_frame(8'h00, 8'h00, 8'h00, 8'h00, body, 1'b0);
    send_frame(HdrSync, HdrSync, 8'hF0, 8'hFF, body, 1'b0);
    send_frame(HdrSync, HdrSync, HdrId, 8'hFF, body, 1'b0);

    while (n_sent < RandBytes) begin
      sel = $urandom_range(99);
      for (int i = 0; i < PayloadLen; i++) body[i] = byte_t'($urandom);
      hdr = '{HdrSync, HdrSync, HdrId, byte_t'($urandom)};
      if (sel < 70) begin
        send_frame(hdr[0], hdr[1], hdr[2], hdr[3], body, 1'b0);
      end else if (sel < 82) begin
        send_frame(hdr[0], hdr[1], hdr[2], hdr[3], body, 1'b1);
      end else if (sel < 92) begin
        n = $urandom_range(2);
        hdr[n] = hdr[n] ^ byte_t'($urandom_range(1, 255));
        send_frame(hdr[0], hdr[1], hdr[2], hdr[3], body, 1'b0);
      end else begin
        // Noise burst, then pad with zeros until a new frame would start.
        n = $urandom_range(1, 40);
        repeat (n) send_byte(byte_t'($urandom));
        while (sb.pos != '0) send_byte(8'h00);
      end
    end
    rx_if.valid <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (sb.n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
